FILE: hdl/fsfx_pkg.sv
// shared constants, types and helpers for the sentence framer with xor check
// no dependencies; imported by fsfx_scan and fixed_sentence_framer_xor_check
package fsfx_pkg;

    localparam int FRAME_LEN = 20;
    localparam int ADDR_W    = $clog2(FRAME_LEN);
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);

    localparam logic [ADDR_W-1:0] FIRST_IDX = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(FRAME_LEN - 1);
    localparam logic [ADDR_W-1:0] SUM_FIRST = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] SUM_LAST  = ADDR_W'(15);
    localparam logic [ADDR_W-1:0] HEX_HI    = ADDR_W'(17);
    localparam logic [ADDR_W-1:0] HEX_LO    = ADDR_W'(18);

    localparam logic [7:0] START_RESET  = 8'h24;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_A_OFF  = 8'h37;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic [7:0]        sum;
        logic              match;
        logic              found;
        logic [ADDR_W-1:0] pos;
    } scan_status_t;

    // upper-case ascii hex digit of one nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10)
        begin
            return ASCII_ZERO + wide;
        end
        return ASCII_A_OFF + wide;
    endfunction

endpackage

FILE: hdl/fsfx_scan.sv
// scan unit: folds one stored byte per cycle into checksum, check digits and start search
// depends on fsfx_pkg
module fsfx_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [7:0]                 start_char,
    input  logic                       rd_vld,
    input  logic [fsfx_pkg::ADDR_W-1:0] rd_tag,
    input  logic [7:0]                 rd_data,
    output fsfx_pkg::scan_status_t     status
);
    import fsfx_pkg::*;

    logic [7:0]        sum_reg;
    logic              found_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [7:0]        hi_reg;
    logic [7:0]        lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= 8'h00;
            found_reg <= 1'b0;
            pos_reg   <= FIRST_IDX;
        end
        else if (rd_vld)
        begin
            if (rd_tag == FIRST_IDX)
            begin
                // start byte: fresh pass
                sum_reg   <= 8'h00;
                found_reg <= 1'b0;
                pos_reg   <= FIRST_IDX;
            end
            else
            begin
                if (rd_tag >= SUM_FIRST && rd_tag <= SUM_LAST)
                begin
                    sum_reg <= sum_reg ^ rd_data;
                end
                // first later start byte wins
                if (!found_reg && rd_data == start_char)
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= rd_tag;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld && rd_tag == HEX_HI)
        begin
            hi_reg <= rd_data;
        end
        if (rd_vld && rd_tag == HEX_LO)
        begin
            lo_reg <= rd_data;
        end
    end

    always_comb
    begin
        status.sum   = sum_reg;
        status.match = (hi_reg == hex_digit(sum_reg[7:4])) &&
                       (lo_reg == hex_digit(sum_reg[3:0]));
        status.found = found_reg;
        status.pos   = pos_reg;
    end

endmodule

FILE: hdl/fixed_sentence_framer_xor_check.sv
// top level of the sentence framer: frame store memory, sequencer and output register
// depends on fsfx_pkg and fsfx_scan
//
// channel   direction  handshake                 payload
// input     in         in_valid / in_stall       byte_in
// output    out        out_valid / out_stall     kind, data, last
// config    in         cfg_valid / cfg_ready     cfg_data (start_char)
//
// one input word is taken per cycle while no sentence is complete; a word that
// completes the sentence starts a scan pass over the single read port of the
// frame store; a match then emits FRAME_LEN words, each first read and then
// loaded into the output register; a mismatch emits one error word and, when a
// later start byte was found, moves the tail down from it, one read and one
// write of the store per cycle
// output stalls hold the sequencer; the output register lets a new input word
// in while the last result still waits
// reset clears control state only; the frame store needs no clearing pass
module fixed_sentence_framer_xor_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] data,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import fsfx_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN     = 4'd1;
    localparam logic [3:0] S_SCAN_END = 4'd2;
    localparam logic [3:0] S_DECIDE   = 4'd3;
    localparam logic [3:0] S_EMIT_RD  = 4'd4;
    localparam logic [3:0] S_EMIT_LD  = 4'd5;
    localparam logic [3:0] S_ERR      = 4'd6;
    localparam logic [3:0] S_COPY     = 4'd7;
    localparam logic [3:0] S_COPY_END = 4'd8;

    // frame store, one write and one registered read per cycle
    logic [7:0] store_mem [FRAME_LEN];

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [7:0]        start_char_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_tag_reg;
    logic              scan_vld_reg, scan_vld_next;
    logic              copy_vld_reg, copy_vld_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    logic              out_valid_reg;
    logic              kind_reg;
    logic [7:0]        data_reg;
    logic              last_reg;
    logic              out_free;
    logic              out_load;
    logic              load_kind;
    logic [7:0]        load_data;
    logic              load_last;

    logic              in_accept;
    scan_status_t      scan_status;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign last      = last_reg;

    fsfx_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_char (start_char_reg),
        .rd_vld     (scan_vld_reg),
        .rd_tag     (rd_tag_reg),
        .rd_data    (rd_data_reg),
        .status     (scan_status)
    );

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        dst_next      = dst_reg;
        fill_next     = fill_reg;
        rd_addr       = idx_reg;
        scan_vld_next = 1'b0;
        copy_vld_next = 1'b0;
        out_load      = 1'b0;
        load_kind     = KIND_BYTE;
        load_data     = rd_data_reg;
        load_last     = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = fill_reg[ADDR_W-1:0];
        wr_data       = byte_in;

        // tail move: write lands in the cycle after its read
        if (copy_vld_reg)
        begin
            wr_en    = 1'b1;
            wr_addr  = dst_reg;
            wr_data  = rd_data_reg;
            dst_next = dst_reg + ADDR_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (fill_reg == CNT_W'(0))
                    begin
                        // hunting for the start character
                        if (byte_in == start_char_reg)
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = FIRST_IDX;
                            fill_next = CNT_W'(1);
                        end
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        if (fill_reg == CNT_W'(FRAME_LEN - 1))
                        begin
                            idx_next   = FIRST_IDX;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                end
            end
            S_SCAN:
            begin
                scan_vld_next = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (scan_status.match)
                begin
                    idx_next   = FIRST_IDX;
                    fill_next  = CNT_W'(0);
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_ERR;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                // read address held so the read word stays put while stalled
                if (out_free)
                begin
                    out_load  = 1'b1;
                    load_kind = KIND_BYTE;
                    load_data = rd_data_reg;
                    load_last = (idx_reg == LAST_IDX);
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    load_kind = KIND_ERROR;
                    load_data = scan_status.sum;
                    load_last = 1'b1;
                    if (scan_status.found)
                    begin
                        idx_next   = scan_status.pos;
                        dst_next   = FIRST_IDX;
                        fill_next  = CNT_W'(FRAME_LEN) - CNT_W'(scan_status.pos);
                        state_next = S_COPY;
                    end
                    else
                    begin
                        fill_next  = CNT_W'(0);
                        state_next = S_IDLE;
                    end
                end
            end
            S_COPY:
            begin
                copy_vld_next = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_COPY_END;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_COPY_END:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
        rd_tag_reg  <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= FIRST_IDX;
            dst_reg        <= FIRST_IDX;
            fill_reg       <= CNT_W'(0);
            start_char_reg <= START_RESET;
            scan_vld_reg   <= 1'b0;
            copy_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            dst_reg      <= dst_next;
            fill_reg     <= fill_next;
            scan_vld_reg <= scan_vld_next;
            copy_vld_reg <= copy_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                start_char_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg <= load_kind;
            data_reg <= load_data;
            last_reg <= load_last;
        end
    end

    // fill count stays below a full sentence between words
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CNT_W'(FRAME_LEN))
        else $error("fill count reached a full sentence");

    // the output register is only loaded when free, so no word is overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output word overwritten");

    // input writes and tail-move writes never share the store write port
    a_write_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && copy_vld_reg))
        else $error("write port conflict");

    // a later start byte is never at the front, so the tail move always shifts
    a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERR && scan_status.found) |-> (scan_status.pos != FIRST_IDX))
        else $error("rescan found the dropped start byte");

endmodule

FILE: dv/tb_fixed_sentence_framer_xor_check.sv
// testbench for fixed_sentence_framer_xor_check: builds sentences, drives bytes and checks every
// output word against a byte-level prediction of the framer kept alongside the block
// depends on fsfx_pkg (frame geometry, kind codes, reset start character) and the block itself
module tb_fixed_sentence_framer_xor_check;
    timeunit 1ns;
    timeprecision 1ps;

    import fsfx_pkg::*;

    // enough idle cycles to cover a full scan pass plus the longest tail move
    localparam int SETTLE_CYCLES = 3 * FRAME_LEN;
    // receiver hold-off long enough to fill the frame store and the output register
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_BYTES  = 160;
    localparam int PHASES        = 4;
    localparam int IDLE_PCT      = 12;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CASE_BIT     = 8'h20;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } framer_word_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] byte_in   = 8'h00;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_stall;
    logic       out_valid;
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic       cfg_ready;

    // shadow of the framer: sentence buffer, fill level and active start character
    logic [7:0] sentence_buf [FRAME_LEN];
    int         sentence_fill = 0;
    logic [7:0] start_byte    = START_RESET;

    // words the block still owes us, oldest first
    framer_word_t owed_words [$];

    // sentence under construction on the sending side
    logic [7:0] tx_frame [FRAME_LEN];

    int fail_count   = 0;
    int framed_bytes = 0;
    int tx_idle_pct  = IDLE_PCT;
    int rx_idle_pct  = IDLE_PCT;
    int rx_hold_req  = 0;
    int rx_hold_left = 0;

    fixed_sentence_framer_xor_check i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .byte_in   (byte_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data      (data),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // upper-case ascii rendering of one nibble
    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CHAR_ZERO + 8'(nib);
        end
        return CHAR_UPPER_A + 8'(nib) - 8'd10;
    endfunction

    // append one word to the owed list
    function automatic void owe_word(input framer_word_t w);
        owed_words = {owed_words, w};
    endfunction

    // advance the shadow framer by one accepted byte and queue the words it owes
    function automatic void frame_byte(input logic [7:0] b);
        logic [7:0] sum;
        int         pos;
        // closed: anything but the start character is dropped
        if (sentence_fill == 0)
        begin
            if (b == start_byte)
            begin
                sentence_buf[0] = b;
                sentence_fill   = 1;
            end
            return;
        end
        sentence_buf[sentence_fill] = b;
        sentence_fill++;
        if (sentence_fill < FRAME_LEN)
        begin
            return;
        end
        sum = 8'h00;
        for (int i = SUM_FIRST; i <= SUM_LAST; i++)
        begin
            sum ^= sentence_buf[i];
        end
        // check digits must be the exact upper-case rendering, high nibble first
        if (sentence_buf[HEX_HI] == ascii_hex(sum[7:4]) &&
            sentence_buf[HEX_LO] == ascii_hex(sum[3:0]))
        begin
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                owe_word(framer_word_t'{KIND_BYTE, sentence_buf[i],
                                        1'(i == FRAME_LEN - 1)});
            end
            sentence_fill = 0;
            return;
        end
        owe_word(framer_word_t'{KIND_ERROR, sum, 1'b1});
        // drop the start byte and resume from the next start character, if any
        pos = 1;
        while (pos < FRAME_LEN && sentence_buf[pos] != start_byte)
        begin
            pos++;
        end
        if (pos >= FRAME_LEN)
        begin
            sentence_fill = 0;
        end
        else
        begin
            for (int i = 0; i < FRAME_LEN - pos; i++)
            begin
                sentence_buf[i] = sentence_buf[i + pos];
            end
            sentence_fill = FRAME_LEN - pos;
        end
    endfunction

    // random sentence body; clean keeps the start character out of bytes 1 and up
    function automatic void fill_body(input logic [7:0] st, input bit clean);
        tx_frame[0] = st;
        for (int i = 1; i < FRAME_LEN; i++)
        begin
            tx_frame[i] = 8'($urandom_range(255));
            if (clean && tx_frame[i] == st)
            begin
                tx_frame[i] = st ^ 8'h01;
            end
        end
    endfunction

    // write the correct check digits for the current body
    function automatic void seal_frame();
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = SUM_FIRST; i <= SUM_LAST; i++)
        begin
            sum ^= tx_frame[i];
        end
        tx_frame[HEX_HI] = ascii_hex(sum[7:4]);
        tx_frame[HEX_LO] = ascii_hex(sum[3:0]);
    endfunction

    // offer one byte, with random gaps ahead of it; valid stays up afterwards so
    // back-to-back words never toggle it within one step
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        // only bytes the framer keeps count toward the stimulus volume
        if (sentence_fill != 0 || b == start_byte)
        begin
            framed_bytes++;
        end
        frame_byte(b);
    endtask

    task automatic send_frame(input int first, input int count);
        for (int i = first; i < first + count; i++)
        begin
            send_byte(tx_frame[i]);
        end
    endtask

    // stop offering, wait for every owed word, then let the scan or tail move finish
    task automatic drain();
        in_valid <= 1'b0;
        while (owed_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // start character update, only ever with the block idle
    task automatic write_start(input logic [7:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        start_byte  = value;
    endtask

    // dropped noise, a clean sentence with extreme body bytes
    task automatic test_noise_and_extremes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(start_byte ^ 8'h01);
        fill_body(start_byte, 1'b1);
        tx_frame[1]  = 8'h00;
        tx_frame[2]  = 8'hFF;
        tx_frame[15] = 8'hFF;
        seal_frame();
        send_frame(0, FRAME_LEN);
        drain();
    endtask

    // lower-case digits, a non-hex digit and a plain wrong digit all fail the check
    task automatic test_bad_checks();
        do
        begin
            fill_body(start_byte, 1'b1);
            seal_frame();
        end
        while (tx_frame[HEX_HI] < CHAR_UPPER_A);
        tx_frame[HEX_HI] |= CASE_BIT;
        send_frame(0, FRAME_LEN);
        fill_body(start_byte, 1'b1);
        seal_frame();
        tx_frame[HEX_LO] = CHAR_G;
        send_frame(0, FRAME_LEN);
        fill_body(start_byte, 1'b1);
        seal_frame();
        tx_frame[HEX_LO] ^= 8'h01;
        send_frame(0, FRAME_LEN);
        drain();
    endtask

    // a start character inside a failing sentence becomes the new sentence head;
    // one inside a passing sentence is just data
    task automatic test_rescan();
        fill_body(start_byte, 1'b1);
        seal_frame();
        send_byte(start_byte);
        repeat (4) send_byte(start_byte ^ 8'h80);
        send_frame(0, 15);
        send_frame(15, 5);
        fill_body(start_byte, 1'b0);
        tx_frame[7] = start_byte;
        seal_frame();
        send_frame(0, FRAME_LEN);
        drain();
    endtask

    // extreme start characters, and a change while a sentence is half stored
    task automatic test_start_change();
        write_start(8'h00);
        fill_body(8'h00, 1'b1);
        seal_frame();
        send_frame(0, FRAME_LEN);
        write_start(8'hFF);
        send_byte(START_RESET);
        fill_body(8'hFF, 1'b1);
        seal_frame();
        send_frame(0, 6);
        // the stored 0xff head still counts as the start byte
        write_start(8'h40);
        send_frame(6, FRAME_LEN - 6);
        write_start(START_RESET);
    endtask

    // receiver holds off long enough that the block backs up into the input
    task automatic test_backpressure();
        rx_hold_req = HOLD_CYCLES;
        repeat (3)
        begin
            fill_body(start_byte, 1'b1);
            seal_frame();
            send_frame(0, FRAME_LEN);
        end
        drain();
    endtask

    // mostly well-formed sentences with random content, plus noise, bad digits
    // and cut-off sentences; one phase per start character, one without idling
    task automatic test_random();
        int         pick;
        int         goal;
        logic [7:0] st;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: st = 8'($urandom_range(255));
                1: st = 8'h00;
                2: st = 8'hFF;
                default: st = START_RESET;
            endcase
            write_start(st);
            tx_idle_pct = (ph == 1) ? 0 : IDLE_PCT;
            rx_idle_pct = (ph == 1) ? 0 : IDLE_PCT;
            goal = framed_bytes + RANDOM_BYTES / PHASES;
            while (framed_bytes < goal)
            begin
                pick = $urandom_range(99);
                fill_body(start_byte, pick < 50);
                seal_frame();
                if (pick < 65)
                begin
                    send_frame(0, FRAME_LEN);
                end
                else if (pick < 80)
                begin
                    tx_frame[$urandom_range(HEX_HI, HEX_LO)] = 8'($urandom_range(255));
                    send_frame(0, FRAME_LEN);
                end
                else if (pick < 90)
                begin
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
                end
                else
                begin
                    send_frame(0, $urandom_range(1, FRAME_LEN - 1));
                end
            end
        end
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (rx_hold_req != 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0)
        begin
            out_stall <= 1'b1;
            rx_hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // every word taken from the block must match the oldest owed word
    always @(posedge clk)
    begin
        framer_word_t got;
        framer_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = framer_word_t'{kind, data, last};
            if (owed_words.size() == 0)
            begin
                fail_count++;
                $display({"%0t: unexpected word, expected none, ",
                          "actual kind=%0b data=%02h last=%0b"},
                         $time, got.kind, got.data, got.last);
            end
            else
            begin
                want = owed_words.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    $display({"%0t: expected kind=%0b data=%02h last=%0b, ",
                              "actual kind=%0b data=%02h last=%0b"},
                             $time, want.kind, want.data, want.last,
                             got.kind, got.data, got.last);
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_noise_and_extremes();
        test_bad_checks();
        test_rescan();
        test_start_change();
        test_backpressure();
        test_random();
        drain();
        if (fail_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
